// ===== src/irc_pkg.sv =====
`default_nettype none
package irc_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int TICK_US = 50;

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

	// rounding sum (elapsed_us + half a tick) and its reciprocal multiply
	localparam int SUM_W = 17;
	localparam int RECIP_K = SUM_W + $clog2(TICK_US);
	localparam int RECIP_W = SUM_W + 2;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((64'd1 << RECIP_K) + TICK_US - 1) / TICK_US);
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_FRAME_GAP = 2'd0;
	localparam logic [1:0] REG_MIN_DUR = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	localparam logic [15:0] FRAME_GAP_RST = 16'd5000;
	localparam logic [8:0] MIN_DUR_RST = 9'd4;
	localparam logic [8:0] CAPACITY_RST = 9'd256;

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_POLL = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EXEC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic calc;
		logic exec;
		logic ld_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [15:0] frame_gap_us;
		logic [8:0] min_durations;
		logic [8:0] frame_capacity;
	} cfg_regs_t;

endpackage
`default_nettype wire

// ===== src/irc_cfg.sv =====
`default_nettype none
module irc_cfg
	import irc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_regs_t cfg
);

	logic [15:0] frame_gap_q;
	logic [8:0] min_dur_q;
	logic [8:0] capacity_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_gap_q <= FRAME_GAP_RST;
			min_dur_q <= MIN_DUR_RST;
			capacity_q <= CAPACITY_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_FRAME_GAP: frame_gap_q <= pwdata[15:0];
				REG_MIN_DUR: min_dur_q <= pwdata[8:0];
				REG_CAPACITY: capacity_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FRAME_GAP: prdata = {16'd0, frame_gap_q};
			REG_MIN_DUR: prdata = {23'd0, min_dur_q};
			REG_CAPACITY: prdata = {23'd0, capacity_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg.frame_gap_us = frame_gap_q;
	assign cfg.min_durations = min_dur_q;
	assign cfg.frame_capacity = capacity_q;

endmodule
`default_nettype wire

// ===== src/irc_ctrl.sv =====
`default_nettype none
module irc_ctrl
	import irc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic out_valid_q;
	logic out_free;

	assign out_free = ~out_valid_q | out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_CALC;
			ST_CALC: state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = ST_EMIT;
			ST_EMIT: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.ld_in = in_valid;
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_EMIT: cmd.ld_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the word until taken; a new load replaces it in the same edge
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/irc_dp.sv =====
`default_nettype none
module irc_dp
	import irc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire ctrl_cmd_t cmd,
	input wire cfg_regs_t cfg,
	input wire logic [31:0] in_data,
	input wire logic [1:0] in_user,
	output logic [23:0] out_data
);

	// input word
	op_t op_q;
	logic [15:0] us_q;
	logic mark_q;
	logic [7:0] idx_q;

	logic [PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] quo;
	logic [7:0] ticks;
	logic too_long;

	// frame state
	logic capt_q, ready_q, pend_q, exp_space_q, ovf_q, clip_q;
	logic [CNT_W-1:0] count_q;
	logic capt_n, ready_n, pend_n, exp_space_n, ovf_n, clip_n;
	logic [CNT_W-1:0] count_n;
	logic wr_en;

	logic [7:0] tick_store [STORE_DEPTH];
	logic [7:0] rd_data_q;
	logic rd_ok_q;
	logic [23:0] out_q;

	logic [CMP_W-1:0] count_x, cap_eff, min_x, idx_x;
	logic gap_ok, full, enough;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q <= op_t'(in_user);
			us_q <= in_data[15:0];
			mark_q <= in_data[16];
			idx_q <= in_data[24:17];
		end
	end

	assign sum = SUM_W'(us_q) + SUM_W'(TICK_US / 2);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			prod_s1 <= PROD_W'(sum) * PROD_W'(RECIP_M);
		end
	end

	assign quo = SUM_W'(prod_s1[PROD_W-1:RECIP_K]);
	assign too_long = (quo > SUM_W'(255));
	always_comb begin
		if (quo == '0) begin
			ticks = 8'd1;
		end else if (too_long) begin
			ticks = 8'd255;
		end else begin
			ticks = quo[7:0];
		end
	end

	assign count_x = CMP_W'(count_q);
	assign cap_eff = (CMP_W'(cfg.frame_capacity) < CMP_W'(STORE_DEPTH)) ?
		CMP_W'(cfg.frame_capacity) : CMP_W'(STORE_DEPTH);
	assign min_x = CMP_W'(cfg.min_durations);
	assign idx_x = CMP_W'(idx_q);
	assign gap_ok = (us_q >= cfg.frame_gap_us);
	assign full = (count_x >= cap_eff);
	assign enough = (count_x >= min_x);

	always_comb begin
		capt_n = capt_q;
		ready_n = ready_q;
		pend_n = pend_q;
		exp_space_n = exp_space_q;
		ovf_n = ovf_q;
		clip_n = clip_q;
		count_n = count_q;
		wr_en = 1'b0;
		case (op_q)
			OP_EDGE: begin
				if (ready_q) begin
					pend_n = 1'b0;
				end else if (!capt_q) begin
					if (mark_q && gap_ok) begin
						capt_n = 1'b1;
						exp_space_n = 1'b0;
						ovf_n = 1'b0;
						clip_n = 1'b0;
						count_n = '0;
					end
				end else if (exp_space_q && gap_ok) begin
					if (enough) begin
						ready_n = 1'b1;
						pend_n = mark_q;
					end else begin
						// short frame: restart empty
						exp_space_n = 1'b0;
						ovf_n = 1'b0;
						clip_n = 1'b0;
						count_n = '0;
					end
				end else begin
					exp_space_n = ~exp_space_q;
					if (full) begin
						ovf_n = 1'b1;
					end else begin
						wr_en = 1'b1;
						count_n = count_q + 1'b1;
						if (too_long) clip_n = 1'b1;
					end
				end
			end
			OP_POLL: begin
				if (!ready_q && capt_q && exp_space_q && enough && gap_ok) ready_n = 1'b1;
			end
			OP_CLEAR: begin
				capt_n = pend_q;
				ready_n = 1'b0;
				pend_n = 1'b0;
				exp_space_n = 1'b0;
				ovf_n = 1'b0;
				clip_n = 1'b0;
				count_n = '0;
			end
			OP_READ: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capt_q <= 1'b0;
			ready_q <= 1'b0;
			pend_q <= 1'b0;
			exp_space_q <= 1'b0;
			ovf_q <= 1'b0;
			clip_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.exec) begin
			capt_q <= capt_n;
			ready_q <= ready_n;
			pend_q <= pend_n;
			exp_space_q <= exp_space_n;
			ovf_q <= ovf_n;
			clip_q <= clip_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			tick_store[count_q[IDX_W-1:0]] <= ticks;
		end
		if (cmd.exec) begin
			rd_data_q <= tick_store[IDX_W'(idx_q)];
			rd_ok_q <= (op_q == OP_READ) && (idx_x < count_x) &&
				(idx_x < CMP_W'(STORE_DEPTH));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_q <= {3'd0, (rd_ok_q ? rd_data_q : 8'd0), clip_q, ovf_q,
				9'(count_q), capt_q, ready_q};
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== src/ir_raw_frame_capture_top.sv =====
// Infrared raw frame capture.
// Command words come in on the s_ stream: s_tuser carries the opcode (edge, poll,
// clear, read) and s_tdata the elapsed time, the mark flag and the read index.
// Every command gives exactly one status word on the m_ stream: frame ready,
// capturing, duration count, overflow and clip flags, and the duration read.
// Durations are stored in ticks in a 256 x 8 on-chip store.
// The controller takes one command at a time and steps it through accept,
// reciprocal multiply, state update with store access and output load; the
// status word is registered in the output-load step and then held on m_tdata.
// The output register parts the two sides; a status word waiting on m_tready
// does not stop the next command from being accepted, and a stalled receiver
// only holds the block in its output-load step until the word is taken.
// Reset clears all frame state and restores the register defaults
// (frame_gap_us 5000, min_durations 4, frame_capacity 256); store contents
// stay undefined, entries are only read below the stored count.
// The APB port (registers at 0x0, 0x4, 0x8) should be written while idle.
`default_nettype none
module ir_raw_frame_capture_top
	import irc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // elapsed_us[15:0], mark_starting[16], read_index[24:17]
	input wire logic [1:0] s_tuser, // opcode[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	// frame_ready[0], capturing[1], duration_count[10:2], overflow_flag[11],
	// clipped_flag[12], read_ticks[20:13]
	output logic [23:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	ctrl_cmd_t cmd;
	cfg_regs_t cfg;

	irc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	irc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd(cmd)
	);

	irc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.in_data(s_tdata),
		.in_user(s_tuser),
		.out_data(m_tdata)
	);

endmodule
`default_nettype wire
